FILE: src/matrix_inverse_gauss_jordan_defines.svh
// Assertion macros shared by the matrix inverse RTL
`ifndef MATRIX_INVERSE_GAUSS_JORDAN_DEFINES_SVH
`define MATRIX_INVERSE_GAUSS_JORDAN_DEFINES_SVH
// Implication checked on every clock edge outside reset
`define MIG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset
`define MIG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: src/mig_pkg.sv
// Package: sizes, types and fixed-point helpers for the matrix inverse
`default_nettype none
package mig_pkg;
    localparam int ORDER     = 3;
    localparam int FRAC_BITS = 16;
    localparam int CELLS     = ORDER * ORDER;
    localparam int IDX_W     = $clog2(CELLS);
    localparam int ROW_W     = $clog2(ORDER);
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic [31:0]        ONE_FX  = 32'd1 << FRAC_BITS;

    typedef struct packed {
        logic        last;
        logic [31:0] elem;
        logic [IDX_W-1:0] idx;
    } t_load;

    typedef enum logic [3:0] {
        ST_LOAD, ST_PIV_RD, ST_PIV_CHK, ST_DIV_RD, ST_DIV_GO, ST_DIV_WAIT,
        ST_FAC_RD, ST_FAC_LAT, ST_SUB_RD, ST_SUB_MUL, ST_SUB_PROD, ST_SUB_WR,
        ST_NEXT_ROW, ST_EMIT_RD, ST_EMIT
    } t_state;

    // Saturate a 64-bit signed value to 32 bits
    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'(S32_MAX)) sat32 = S32_MAX;
        else if (v < 64'(S32_MIN)) sat32 = S32_MIN;
        else sat32 = v[31:0];
    endfunction

    // Diagonal positions of a row-major ORDER x ORDER matrix
    function automatic logic [CELLS-1:0] diag_mask();
        logic [CELLS-1:0] m;
        m = '0;
        for (int r = 0; r < ORDER; r++) m[r * ORDER + r] = 1'b1;
        return m;
    endfunction

    localparam logic [CELLS-1:0] DIAG = diag_mask();
endpackage
`default_nettype wire

FILE: src/mig_ram.sv
// Generic single-write, single-read RAM with registered read
`default_nettype none
module mig_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 9
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: src/mig_front.sv
// Front end: takes input beats, numbers them and queues them for the engine
`default_nettype none
module mig_front
    import mig_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_elem,
    input  wire logic        i_last,
    output logic             o_q_valid,
    input  wire logic        i_q_pop,
    output t_load            o_q_head
);
    t_load              r_q [QDEPTH];
    logic [QCNT_W-1:0]  r_cnt;
    logic [QPTR_W-1:0]  r_wp, r_rp;
    logic [IDX_W-1:0]   r_idx;
    logic               push;
    logic               mark;

    assign o_ready   = (r_cnt != QCNT_W'(QDEPTH));
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_head  = r_q[r_rp];
    // a beat closes the matrix on its mark or when it fills the last position
    assign mark      = i_last || (r_idx == IDX_W'(CELLS - 1));

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp].elem <= i_elem;
            r_q[r_wp].idx  <= r_idx;
            r_q[r_wp].last <= mark;
        end
    end

    // pointers, fill and position count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0; r_wp <= '0; r_rp <= '0; r_idx <= '0;
        end else begin
            if (push) begin
                r_wp  <= (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
                r_idx <= mark ? '0 : r_idx + 1'b1;
            end
            if (i_q_pop) r_rp <= (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + QCNT_W'(push) - QCNT_W'(i_q_pop);
        end
    end

`include "matrix_inverse_gauss_jordan_defines.svh"
    `MIG_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, i_q_pop, o_q_valid)
    `MIG_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= QCNT_W'(QDEPTH))
    `MIG_ASSERT_IMP(a_idx_range, i_clk, i_rst_n, 1'b1, r_idx < IDX_W'(CELLS))
endmodule
`default_nettype wire

FILE: src/mig_divider.sv
// Restoring divider: signed (a << FRAC_BITS) / p, one quotient bit a cycle
`default_nettype none
module mig_divider
    import mig_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_done,
    output logic [31:0]      o_quot
);
    localparam int NW = 32 + FRAC_BITS;
    logic [NW-1:0] r_q;
    logic [32:0]   r_rem;
    logic [31:0]   r_d;
    logic          r_neg, r_busy;
    logic [$clog2(NW+1)-1:0] r_cnt;
    logic [33:0]   trial;
    logic [63:0]   mag;

    assign trial = {r_rem, r_q[NW-1]} - {2'b00, r_d};
    assign mag   = 64'(r_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= ($clog2(NW+1))'(NW);
                r_rem  <= '0;
                r_neg  <= i_num[31] ^ i_den[31];
                r_d    <= i_den[31] ? 32'(-i_den) : i_den;
                r_q    <= NW'({(i_num[31] ? 32'(-i_num) : i_num), FRAC_BITS'(0)});
            end else if (r_busy) begin
                if (trial[33]) begin
                    r_rem <= {r_rem[31:0], r_q[NW-1]};
                    r_q   <= {r_q[NW-2:0], 1'b0};
                end else begin
                    r_rem <= trial[32:0];
                    r_q   <= {r_q[NW-2:0], 1'b1};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 1) begin
                    r_busy <= 1'b0; o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = sat32(r_neg ? -$signed(mag) : $signed(mag));
endmodule
`default_nettype wire

FILE: src/mig_engine.sv
// Back end: stores the matrix, runs the elimination and streams the inverse
`default_nettype none
module mig_engine
    import mig_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_q_valid,
    output logic             o_q_pop,
    input  wire t_load       i_q_head,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_elem,
    output logic             o_last,
    output logic             o_sing
);
    t_state             r_st, n_st;
    logic [ROW_W-1:0]   r_i, n_i, r_e, n_e, r_j, n_j;
    logic               r_side, n_side, r_sing, n_sing;
    logic [IDX_W-1:0]   r_k, n_k;
    logic [31:0]        r_piv, n_piv, r_f, n_f, r_a, n_a, r_tgt, n_tgt;
    logic signed [63:0] r_prod, n_prod;
    logic [31:0]        r_out, n_out;
    logic               r_ov, n_ov, r_ol, n_ol, r_os, n_os;
    logic [CELLS-1:0]   r_iv_ok, n_iv_ok;
    logic [IDX_W-1:0]   r_iv_ra;

    logic               wm_we, iv_we;
    logic [IDX_W-1:0]   wm_wa, iv_wa, wm_ra, iv_ra;
    logic [31:0]        wm_wd, iv_wd, wm_rd, iv_rd;
    logic               div_start, div_done;
    logic [31:0]        div_num, div_q, rd_sel, iv_val, sub_val;
    logic signed [63:0] pdiv;

    function automatic logic [IDX_W-1:0] cell_idx(input logic [ROW_W-1:0] r,
                                                  input logic [ROW_W-1:0] c);
        cell_idx = IDX_W'(r * ORDER + c);
    endfunction

    mig_ram #(.WIDTH(32), .DEPTH(CELLS)) u_wm (.i_clk, .i_we(wm_we), .i_waddr(wm_wa),
        .i_wdata(wm_wd), .i_raddr(wm_ra), .o_rdata(wm_rd));
    mig_ram #(.WIDTH(32), .DEPTH(CELLS)) u_iv (.i_clk, .i_we(iv_we), .i_waddr(iv_wa),
        .i_wdata(iv_wd), .i_raddr(iv_ra), .o_rdata(iv_rd));
    mig_divider u_div (.i_clk, .i_rst_n, .i_start(div_start), .i_num(div_num),
        .i_den(r_piv), .o_done(div_done), .o_quot(div_q));

    // inverse side: an entry not yet written this run reads as identity
    assign iv_val  = r_iv_ok[r_iv_ra] ? iv_rd : (DIAG[r_iv_ra] ? ONE_FX : 32'd0);
    assign rd_sel  = r_side ? iv_val : wm_rd;
    assign div_num = rd_sel;
    // product scaled back toward zero, then saturating difference
    assign pdiv    = r_prod[63] ? -((-r_prod) >>> FRAC_BITS) : (r_prod >>> FRAC_BITS);
    assign sub_val = sat32($signed({{32{r_tgt[31]}}, r_tgt})
                           - $signed(64'(signed'(sat32(pdiv)))));

    // sequencing: load, pivot check, row division, elimination, emit
    always_comb begin
        n_st = r_st; n_i = r_i; n_e = r_e; n_j = r_j; n_side = r_side; n_sing = r_sing;
        n_k = r_k; n_piv = r_piv; n_f = r_f; n_a = r_a; n_tgt = r_tgt; n_prod = r_prod;
        n_out = r_out; n_ol = r_ol; n_os = r_os; n_iv_ok = r_iv_ok;
        n_ov = r_ov && !i_ready;
        o_q_pop = 1'b0; div_start = 1'b0;
        wm_we = 1'b0; wm_wa = i_q_head.idx; wm_wd = i_q_head.elem;
        iv_we = 1'b0; iv_wa = cell_idx(r_i, r_j); iv_wd = div_q;
        wm_ra = cell_idx(r_i, r_j); iv_ra = cell_idx(r_i, r_j);
        unique case (r_st)
            ST_LOAD: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1; wm_we = 1'b1;
                    if (i_q_head.last) begin
                        n_st = ST_PIV_RD; n_i = '0; n_sing = 1'b0; n_iv_ok = '0;
                    end
                end
            end
            ST_PIV_RD: begin
                wm_ra = cell_idx(r_i, r_i); n_st = ST_PIV_CHK;
            end
            ST_PIV_CHK: begin
                n_piv = wm_rd; n_j = '0; n_side = 1'b0;
                if (wm_rd == 32'd0) begin
                    n_sing = 1'b1; n_k = '0; n_st = ST_EMIT_RD;
                end else begin
                    n_st = ST_DIV_RD;
                end
            end
            ST_DIV_RD: begin
                n_st = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                div_start = 1'b1; n_st = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    wm_wa = cell_idx(r_i, r_j); wm_wd = div_q;
                    if (r_side) begin
                        iv_we = 1'b1; n_iv_ok[cell_idx(r_i, r_j)] = 1'b1;
                    end else begin
                        wm_we = 1'b1;
                    end
                    if (r_j == ROW_W'(ORDER - 1)) begin
                        n_j = '0;
                        if (r_side) begin
                            n_side = 1'b0; n_e = '0; n_st = ST_FAC_RD;
                        end else begin
                            n_side = 1'b1; n_st = ST_DIV_RD;
                        end
                    end else begin
                        n_j = r_j + 1'b1; n_st = ST_DIV_RD;
                    end
                end
            end
            ST_FAC_RD: begin
                wm_ra = cell_idx(r_e, r_i);
                n_st = (r_e == r_i) ? ST_NEXT_ROW : ST_FAC_LAT;
            end
            ST_FAC_LAT: begin
                n_f = wm_rd; n_j = '0; n_side = 1'b0; n_st = ST_SUB_RD;
            end
            ST_SUB_RD: begin
                // pivot row operand first, then target entry
                n_st = ST_SUB_MUL;
            end
            ST_SUB_MUL: begin
                n_a = rd_sel; wm_ra = cell_idx(r_e, r_j); iv_ra = cell_idx(r_e, r_j);
                n_st = ST_SUB_PROD;
            end
            ST_SUB_PROD: begin
                n_prod = $signed(r_f) * $signed(r_a); n_tgt = rd_sel; n_st = ST_SUB_WR;
            end
            ST_SUB_WR: begin
                wm_wa = cell_idx(r_e, r_j); wm_wd = sub_val;
                iv_wa = cell_idx(r_e, r_j); iv_wd = sub_val;
                if (r_side) begin
                    iv_we = 1'b1; n_iv_ok[cell_idx(r_e, r_j)] = 1'b1;
                end else begin
                    wm_we = 1'b1;
                end
                if (r_j == ROW_W'(ORDER - 1)) begin
                    n_j = '0;
                    if (r_side) begin
                        n_side = 1'b0; n_st = ST_NEXT_ROW;
                    end else begin
                        n_side = 1'b1; n_st = ST_SUB_RD;
                    end
                end else begin
                    n_j = r_j + 1'b1; n_st = ST_SUB_RD;
                end
            end
            ST_NEXT_ROW: begin
                if (r_e == ROW_W'(ORDER - 1)) begin
                    if (r_i == ROW_W'(ORDER - 1)) begin
                        n_k = '0; n_st = ST_EMIT_RD;
                    end else begin
                        n_i = r_i + 1'b1; n_st = ST_PIV_RD;
                    end
                end else begin
                    n_e = r_e + 1'b1; n_st = ST_FAC_RD;
                end
            end
            ST_EMIT_RD: begin
                iv_ra = r_k; n_st = ST_EMIT;
            end
            ST_EMIT: begin
                // keep the address so the read data holds while the output is busy
                iv_ra = r_k;
                if (!r_ov || i_ready) begin
                    n_out = r_sing ? 32'd0 : iv_val; n_ov = 1'b1; n_os = r_sing;
                    n_ol = (r_k == IDX_W'(CELLS - 1));
                    if (r_k == IDX_W'(CELLS - 1)) begin
                        n_st = ST_LOAD;
                    end else begin
                        n_k = r_k + 1'b1; n_st = ST_EMIT_RD;
                    end
                end
            end
            default: n_st = ST_LOAD;
        endcase
    end

    // state and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_LOAD; r_i <= '0; r_e <= '0; r_j <= '0; r_side <= 1'b0;
            r_sing <= 1'b0; r_k <= '0; r_piv <= '0; r_f <= '0; r_a <= '0; r_tgt <= '0;
            r_prod <= '0; r_out <= '0; r_ov <= 1'b0; r_ol <= 1'b0; r_os <= 1'b0;
            r_iv_ok <= '0; r_iv_ra <= '0;
        end else begin
            r_st <= n_st; r_i <= n_i; r_e <= n_e; r_j <= n_j; r_side <= n_side;
            r_sing <= n_sing; r_k <= n_k; r_piv <= n_piv; r_f <= n_f; r_a <= n_a;
            r_tgt <= n_tgt; r_prod <= n_prod; r_out <= n_out; r_ov <= n_ov; r_ol <= n_ol;
            r_os <= n_os; r_iv_ok <= n_iv_ok; r_iv_ra <= iv_ra;
        end
    end

    assign o_valid = r_ov;
    assign o_elem  = r_out;
    assign o_last  = r_ol;
    assign o_sing  = r_os;

`include "matrix_inverse_gauss_jordan_defines.svh"
    `MIG_ASSERT_IMP(a_pop_in_load, i_clk, i_rst_n, o_q_pop, r_st == ST_LOAD)
    `MIG_ASSERT_NXT(a_hold_out, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_elem) && $stable(o_last) && $stable(o_sing))
    `MIG_ASSERT_IMP(a_sing_zero, i_clk, i_rst_n, o_valid && o_sing, o_elem == 32'd0)
    `MIG_ASSERT_IMP(a_div_piv, i_clk, i_rst_n, div_start, r_piv != 32'd0)
endmodule
`default_nettype wire

FILE: src/matrix_inverse_gauss_jordan.sv
// Top level of the Gauss-Jordan matrix inverse
// Takes an ORDER x ORDER Q16.16 matrix one beat per element, row-major (tlast marks
// the final element; a full matrix closes on its own). The engine then runs
// elimination without pivoting with one shared restoring divider (48 iterations
// per quotient, each after its operand read and start) and one multiplier, and
// streams the ORDER*ORDER inverse elements row-major with tlast on the final one and
// tuser as the singular flag (elements zero then). For a 3x3 matrix the work after
// the closing beat is 18 quotients, 6 row updates and the control steps of each
// pivot, so the serial divider sets the pace; results then leave one at a time,
// each held while the output stalls. A zero pivot ends the elimination early.
// Input beats queue in a two-entry buffer while the engine works.
`default_nettype none
module matrix_inverse_gauss_jordan
    import mig_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] elem_in
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] inv_elem
    output logic             m_axis_tlast,
    output logic             m_axis_tuser    // [0] singular
);
    logic  q_valid, q_pop;
    t_load q_head;

    mig_front u_front (.i_clk, .i_rst_n, .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_elem(s_axis_tdata), .i_last(s_axis_tlast), .o_q_valid(q_valid),
        .i_q_pop(q_pop), .o_q_head(q_head));
    mig_engine u_engine (.i_clk, .i_rst_n, .i_q_valid(q_valid), .o_q_pop(q_pop),
        .i_q_head(q_head), .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_elem(m_axis_tdata), .o_last(m_axis_tlast), .o_sing(m_axis_tuser));
endmodule
`default_nettype wire
